// ===== src/aabbrc_pkg.sv =====
package aabbrc_pkg;

  // Fraction bits of the coordinate format. Port widths stay at 32 bits.
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int TOL_W = 16;
  localparam int MODE_W = 2;

  // Default tolerance is 0.001 rounded to the nearest step of the format.
  localparam logic [TOL_W-1:0] TOL_RESET =
      TOL_W'((((64'd1 << COORD_FRAC_BITS) + 64'd500) / 64'd1000));

  // Configuration register indexes.
  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_TOL = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_FULL       = 2'd0,
    MODE_VERTICAL   = 2'd1,
    MODE_HORIZONTAL = 2'd2,
    MODE_SPARE      = 2'd3
  } test_mode_t;

  typedef enum logic [1:0] {
    REL_NONE      = 2'd0,
    REL_OVERLAP   = 2'd1,
    REL_FIRST_IN  = 2'd2,
    REL_SECOND_IN = 2'd3
  } relation_t;

  // Per-axis comparison results.
  typedef struct packed {
    logic sep_tol;  // d >= s1 + s2 - tolerance
    logic sep;      // d >= s1 + s2
    logic in1;      // d + s1 <= s2
    logic in2;      // d + s2 <= s1
  } axis_flags_t;

  // Load enables of the four per-axis stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } axis_ld_t;

endpackage

// ===== src/aabbrc_axis.sv =====
module aabbrc_axis
  import aabbrc_pkg::*;
(
  input  logic                        clk,
  input  axis_ld_t                    ld,
  input  logic [TOL_W-1:0]            tolerance,
  input  logic signed [COORD_W-1:0]   c1,
  input  logic signed [COORD_W-1:0]   h1,
  input  logic signed [COORD_W-1:0]   c2,
  input  logic signed [COORD_W-1:0]   h2,
  output axis_flags_t                 flags
);

  // Stage 1: center difference and half-extent magnitudes.
  logic signed [COORD_W:0] diff_r;
  logic [COORD_W-1:0] s1_a_r, s2_a_r;
  // Stage 2: distance and extent sum.
  logic [COORD_W:0] d_b_r, sum_b_r;
  logic [COORD_W-1:0] s1_b_r, s2_b_r;
  // Stage 3: the three sums that meet the comparators.
  logic [COORD_W+1:0] dt_c_r, a1_c_r, a2_c_r;
  logic [COORD_W:0] d_c_r, sum_c_r;
  logic [COORD_W-1:0] s1_c_r, s2_c_r;
  // Stage 4: flags.
  axis_flags_t flags_r;

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      diff_r <= (COORD_W+1)'(c2) - (COORD_W+1)'(c1);
      s1_a_r <= h1[COORD_W-1] ? COORD_W'(-h1) : COORD_W'(h1);
      s2_a_r <= h2[COORD_W-1] ? COORD_W'(-h2) : COORD_W'(h2);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      d_b_r   <= diff_r[COORD_W] ? (COORD_W+1)'(-diff_r) : (COORD_W+1)'(diff_r);
      sum_b_r <= {1'b0, s1_a_r} + {1'b0, s2_a_r};
      s1_b_r  <= s1_a_r;
      s2_b_r  <= s2_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      dt_c_r  <= {1'b0, d_b_r} + (COORD_W+2)'(tolerance);
      a1_c_r  <= {1'b0, d_b_r} + (COORD_W+2)'(s1_b_r);
      a2_c_r  <= {1'b0, d_b_r} + (COORD_W+2)'(s2_b_r);
      d_c_r   <= d_b_r;
      sum_c_r <= sum_b_r;
      s1_c_r  <= s1_b_r;
      s2_c_r  <= s2_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      flags_r.sep_tol <= dt_c_r >= {1'b0, sum_c_r};
      flags_r.sep     <= d_c_r >= sum_c_r;
      flags_r.in1     <= a1_c_r <= (COORD_W+2)'(s2_c_r);
      flags_r.in2     <= a2_c_r <= (COORD_W+2)'(s1_c_r);
    end
  end

  assign flags = flags_r;

endmodule

// ===== src/aabb_relation_classifier_top.sv =====
// Axis-aligned box relation classifier.
//
// Each input beat carries two boxes, each a center and half-extents on x, y
// and z in signed fixed point. Each output beat carries one relation code:
// no overlap, overlap, first inside second, or second inside first.
// Both channels use valid/ready; a beat moves when both are high.
//
// The cfg port writes test_mode (index 0) and tolerance (index 1).
// It should only be written while no beat is in flight.
//
// The datapath is a five-stage pipeline: center difference and magnitudes,
// absolute distance and extent sum, the tolerance and containment sums, the
// comparators, and the mode-dependent decision. One beat per cycle is
// sustained while the receiver is ready.
//
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out while the receiver
// stalls. in_ready drops only once every stage holds a beat. Reset clears
// all valid bits and loads the default mode and tolerance.
module aabb_relation_classifier_top
  import aabbrc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [COORD_W-1:0]  in_first_center_x,
  input  logic signed [COORD_W-1:0]  in_first_center_y,
  input  logic signed [COORD_W-1:0]  in_first_center_z,
  input  logic signed [COORD_W-1:0]  in_first_half_x,
  input  logic signed [COORD_W-1:0]  in_first_half_y,
  input  logic signed [COORD_W-1:0]  in_first_half_z,
  input  logic signed [COORD_W-1:0]  in_second_center_x,
  input  logic signed [COORD_W-1:0]  in_second_center_y,
  input  logic signed [COORD_W-1:0]  in_second_center_z,
  input  logic signed [COORD_W-1:0]  in_second_half_x,
  input  logic signed [COORD_W-1:0]  in_second_half_y,
  input  logic signed [COORD_W-1:0]  in_second_half_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_relation,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [TOL_W-1:0]           cfg_wdata
);

  localparam int NSTAGE = 5;

  test_mode_t mode_r;
  logic [TOL_W-1:0] tol_r;

  // vld_r[k] is the valid bit of stage k+1; rdy[k] says stage k+1 may load.
  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic [NSTAGE:0] rdy;
  logic [NSTAGE-1:0] ld;

  axis_ld_t axis_ld;
  axis_flags_t fx, fy, fz;
  relation_t rel_r, rel_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FULL;
      tol_r  <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODE: mode_r <= test_mode_t'(cfg_wdata[MODE_W-1:0]);
        CFG_IDX_TOL:  tol_r  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Ready runs backward: a stage loads when it is empty or drains.
  always_comb begin
    rdy[NSTAGE] = out_ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ld = rdy[NSTAGE-1:0];
    vld_nxt[0] = in_valid;
    for (int k = 1; k < NSTAGE; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (ld[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_ready = rdy[0];

  assign axis_ld.s1 = ld[0];
  assign axis_ld.s2 = ld[1];
  assign axis_ld.s3 = ld[2];
  assign axis_ld.s4 = ld[3];

  aabbrc_axis u_axis_x (
    .clk       (clk),
    .ld        (axis_ld),
    .tolerance (tol_r),
    .c1        (in_first_center_x),
    .h1        (in_first_half_x),
    .c2        (in_second_center_x),
    .h2        (in_second_half_x),
    .flags     (fx)
  );

  aabbrc_axis u_axis_y (
    .clk       (clk),
    .ld        (axis_ld),
    .tolerance (tol_r),
    .c1        (in_first_center_y),
    .h1        (in_first_half_y),
    .c2        (in_second_center_y),
    .h2        (in_second_half_y),
    .flags     (fy)
  );

  aabbrc_axis u_axis_z (
    .clk       (clk),
    .ld        (axis_ld),
    .tolerance (tol_r),
    .c1        (in_first_center_z),
    .h1        (in_first_half_z),
    .c2        (in_second_center_z),
    .h2        (in_second_half_z),
    .flags     (fz)
  );

  // Final stage: pick the relation for the selected test. The full test
  // only ever separates or overlaps; the vertical test checks z alone with
  // the tolerance; the horizontal test checks x and y without it. Equal
  // boxes resolve to first inside second since that check comes first.
  always_comb begin
    unique case (mode_r)
      MODE_VERTICAL: begin
        priority if (fz.sep_tol) rel_nxt = REL_NONE;
        else if (fz.in1)         rel_nxt = REL_FIRST_IN;
        else if (fz.in2)         rel_nxt = REL_SECOND_IN;
        else                     rel_nxt = REL_OVERLAP;
      end
      MODE_HORIZONTAL: begin
        priority if (fx.sep || fy.sep) rel_nxt = REL_NONE;
        else if (fx.in1 && fy.in1)     rel_nxt = REL_FIRST_IN;
        else if (fx.in2 && fy.in2)     rel_nxt = REL_SECOND_IN;
        else                           rel_nxt = REL_OVERLAP;
      end
      MODE_FULL, MODE_SPARE: begin
        rel_nxt = (fx.sep_tol || fy.sep_tol || fz.sep_tol) ? REL_NONE : REL_OVERLAP;
      end
      default: rel_nxt = REL_OVERLAP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[NSTAGE-1]) begin
      rel_r <= rel_nxt;
    end
  end

  assign out_valid    = vld_r[NSTAGE-1];
  assign out_relation = rel_r;

endmodule

// ===== src/aabbrc_checker.sv =====
module aabbrc_checker
  import aabbrc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_relation
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_relation))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A receiver that takes beats never back-pressures the input.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
      out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // With the receiver ready, an accepted beat passes through every stage and comes out.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
      $past(in_valid && in_ready && rst_n, 5) &&
      $past(out_ready && rst_n, 4) && $past(out_ready && rst_n, 3) &&
      $past(out_ready && rst_n, 2) && $past(out_ready && rst_n, 1)
      |-> out_valid)
    else $error("accepted beat did not arrive after five cycles");

endmodule

bind aabb_relation_classifier_top aabbrc_checker u_aabbrc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_relation (out_relation)
);
